>>> rtl/bsd_pkg.sv
// bsd_pkg: shared types, codes and constants of the streaming bitmap decoder.
// No dependencies; used by bsd_parser, bsd_result_buf and the top level.
`default_nettype none
package bsd_pkg;

  localparam int unsigned RES_MAX = 9;   // most results one file byte can cause
  localparam int unsigned RES_CW  = 4;   // holds 0..RES_MAX

  typedef enum logic [2:0] {
    KIND_HEADER = 3'd0,
    KIND_MASK   = 3'd1,
    KIND_PAL    = 3'd2,
    KIND_PIX    = 3'd3,
    KIND_RAW    = 3'd4,
    KIND_DONE   = 3'd5,
    KIND_ERR    = 3'd6
  } kind_e;

  typedef enum logic [3:0] {
    ERR_NONE     = 4'd0,
    ERR_NOT_BMP  = 4'd1,
    ERR_HDR_SIZE = 4'd2,
    ERR_PLANES   = 4'd3,
    ERR_DEPTH    = 4'd4,
    ERR_COMPRESS = 4'd5,
    ERR_BF_DEPTH = 4'd6,
    ERR_COLOURS  = 4'd7,
    ERR_OFFSET   = 4'd8,
    ERR_EARLY    = 4'd9,
    ERR_TOO_BIG  = 4'd10
  } err_e;

  typedef enum logic [2:0] {
    PH_HEAD = 3'd0,
    PH_MASK = 3'd1,
    PH_PAL  = 3'd2,
    PH_SKIP = 3'd3,
    PH_PIX  = 3'd4,
    PH_IDLE = 3'd5
  } phase_e;

  typedef struct packed {
    kind_e       kind;
    logic [13:0] column;
    logic [11:0] row;
    logic [31:0] payload;
    err_e        err;
    logic        last;
  } res_t;

  localparam logic [7:0]  MAGIC_B      = 8'h42;
  localparam logic [7:0]  MAGIC_M      = 8'h4D;
  localparam logic [31:0] HDR_OS2      = 32'd12;
  localparam logic [31:0] HDR_WIN      = 32'd40;
  localparam logic [31:0] COMP_RGB     = 32'd0;
  localparam logic [31:0] COMP_BITFLD  = 32'd3;
  localparam logic [31:0] OPAQUE       = 32'hFF00_0000;

  localparam logic [31:0] M16_R = 32'h0000_7C00;
  localparam logic [31:0] M16_G = 32'h0000_03E0;
  localparam logic [31:0] M16_B = 32'h0000_001F;
  localparam logic [31:0] M24_R = 32'h00FF_0000;
  localparam logic [31:0] M24_G = 32'h0000_FF00;
  localparam logic [31:0] M24_B = 32'h0000_00FF;

  // Build one result; column and row are cut to their field widths.
  function automatic res_t mk_res(kind_e kind, logic [31:0] col, logic [31:0] row,
                                  logic [31:0] pay, err_e err);
    res_t r;
    r.kind    = kind;
    r.column  = col[13:0];
    r.row     = row[11:0];
    r.payload = pay;
    r.err     = err;
    r.last    = 1'b0;
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/bsd_parser.sv
// bsd_parser: header, palette and pixel parser; one file byte per beat, all
// results of that byte built in one pass. Depends on bsd_pkg.
`default_nettype none
module bsd_parser #(
  parameter int unsigned MAX_WIDTH   = 4096,
  parameter int unsigned MAX_HEIGHT  = 4096,
  parameter int unsigned MAX_COLOURS = 256
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       accept_i,
  input  wire logic [7:0]                 file_byte_i,
  input  wire logic                       end_of_file_i,
  output bsd_pkg::res_t                   list_o [bsd_pkg::RES_MAX],
  output logic [bsd_pkg::RES_CW-1:0]      count_o
);

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned PW = WW + 3;

  bsd_pkg::phase_e phase_q, phase_d;
  logic [31:0]   pos_q, pos_d, acc_q, acc_d, off_q, off_d;
  logic          win_q, win_d, bf_q, bf_d;
  logic [WW-1:0] wid_q, wid_d;
  logic [HW-1:0] hgt_q, hgt_d, row_q, row_d;
  logic [5:0]    bpp_q, bpp_d;
  logic [8:0]    pcnt_q, pcnt_d, pent_q, pent_d;
  logic [1:0]    psub_q, psub_d;
  logic [PW-1:0] rbc_q, rbc_d, pitch_q, pitch_d;
  logic [23:0]   gath_q, gath_d;

  // scratch of the byte pass
  logic [31:0]    acc_sh, wv, cnt, col_val;
  logic [15:0]    hi16;
  logic           fin, col_en, col_fin, am, go_data, go_pix;
  logic [3:0]     mk;
  logic [WW+5:0]  prod;
  logic [PW+1:0]  pbytes;
  logic [PW+2:0]  x;
  logic [WW+2:0]  rawlim;
  logic [PW-1:0]  rbc_n;
  logic [bsd_pkg::RES_CW-1:0] n;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= bsd_pkg::PH_HEAD;
      pos_q   <= '0; acc_q <= '0; off_q <= '0;
      win_q   <= 1'b0; bf_q <= 1'b0;
      wid_q   <= '0; hgt_q <= '0; row_q <= '0; bpp_q <= '0;
      pcnt_q  <= '0; pent_q <= '0; psub_q <= '0;
      rbc_q   <= '0; pitch_q <= '0; gath_q <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d; acc_q <= acc_d; off_q <= off_d;
      win_q   <= win_d; bf_q <= bf_d;
      wid_q   <= wid_d; hgt_q <= hgt_d; row_q <= row_d; bpp_q <= bpp_d;
      pcnt_q  <= pcnt_d; pent_q <= pent_d; psub_q <= psub_d;
      rbc_q   <= rbc_d; pitch_q <= pitch_d; gath_q <= gath_d;
    end
  end

  // next state and result list of the byte at the input
  always_comb begin
    phase_d = phase_q; pos_d = pos_q + 32'd1; acc_d = acc_q; off_d = off_q;
    win_d = win_q; bf_d = bf_q; wid_d = wid_q; hgt_d = hgt_q; row_d = row_q;
    bpp_d = bpp_q; pcnt_d = pcnt_q; pent_d = pent_q; psub_d = psub_q;
    rbc_d = rbc_q; pitch_d = pitch_q; gath_d = gath_q;
    for (int i = 0; i < int'(bsd_pkg::RES_MAX); i++) list_o[i] = '0;
    n = '0;
    fin = 1'b0; col_en = 1'b0; col_fin = 1'b0; col_val = '0; am = 1'b0;
    go_data = 1'b0; go_pix = 1'b0; cnt = '0;
    acc_sh = {file_byte_i, acc_q[31:8]};
    hi16 = acc_sh[31:16];
    wv = win_q ? acc_sh : {16'd0, hi16};
    mk = pos_q[3:0] - 4'd6;
    x = '0; rbc_n = rbc_q + PW'(1);
    rawlim = (WW+3)'(wid_q) * (WW+3)'(bpp_q[5:3]);

    if (phase_q == bsd_pkg::PH_HEAD || phase_q == bsd_pkg::PH_MASK) acc_d = acc_sh;

    case (phase_q)
      bsd_pkg::PH_HEAD: begin
        if (pos_q == 32'd0) begin
          if (file_byte_i != bsd_pkg::MAGIC_B) begin
            list_o[n] = bsd_pkg::mk_res(bsd_pkg::KIND_ERR, 0, 0, 0, bsd_pkg::ERR_NOT_BMP);
            n = n + 1'b1; phase_d = bsd_pkg::PH_IDLE;
          end
        end else if (pos_q == 32'd1) begin
          if (file_byte_i != bsd_pkg::MAGIC_M) begin
            list_o[n] = bsd_pkg::mk_res(bsd_pkg::KIND_ERR, 0, 0, 0, bsd_pkg::ERR_NOT_BMP);
            n = n + 1'b1; phase_d = bsd_pkg::PH_IDLE;
          end
        end else if (pos_q == 32'd13) begin
          off_d = acc_sh;
        end else if (pos_q == 32'd17) begin
          if (acc_sh == bsd_pkg::HDR_OS2) win_d = 1'b0;
          else if (acc_sh == bsd_pkg::HDR_WIN) win_d = 1'b1;
          else begin
            list_o[n] = bsd_pkg::mk_res(bsd_pkg::KIND_ERR, 0, 0, 0, bsd_pkg::ERR_HDR_SIZE);
            n = n + 1'b1; phase_d = bsd_pkg::PH_IDLE;
          end
        end else if (pos_q == (win_q ? 32'd21 : 32'd19)) begin
          if (wv > 32'(MAX_WIDTH)) begin
            list_o[n] = bsd_pkg::mk_res(bsd_pkg::KIND_ERR, 0, 0, 0, bsd_pkg::ERR_TOO_BIG);
            n = n + 1'b1; phase_d = bsd_pkg::PH_IDLE;
          end else wid_d = wv[WW-1:0];
        end else if (pos_q == (win_q ? 32'd25 : 32'd21)) begin
          if (wv > 32'(MAX_HEIGHT)) begin
            list_o[n] = bsd_pkg::mk_res(bsd_pkg::KIND_ERR, 0, 0, 0, bsd_pkg::ERR_TOO_BIG);
            n = n + 1'b1; phase_d = bsd_pkg::PH_IDLE;
          end else hgt_d = wv[HW-1:0];
        end else if (pos_q == (win_q ? 32'd27 : 32'd23)) begin
          if (hi16 != 16'd1) begin
            list_o[n] = bsd_pkg::mk_res(bsd_pkg::KIND_ERR, 0, 0, 0, bsd_pkg::ERR_PLANES);
            n = n + 1'b1; phase_d = bsd_pkg::PH_IDLE;
          end
        end else if (pos_q == (win_q ? 32'd29 : 32'd25)) begin
          if (hi16 != 16'd1 && hi16 != 16'd4 && hi16 != 16'd8 && hi16 != 16'd16 &&
              hi16 != 16'd24 && hi16 != 16'd32) begin
            list_o[n] = bsd_pkg::mk_res(bsd_pkg::KIND_ERR, 0, 0, 0, bsd_pkg::ERR_DEPTH);
            n = n + 1'b1; phase_d = bsd_pkg::PH_IDLE;
          end else begin
            bpp_d = hi16[5:0];
            if (!win_q) begin
              col_en = 1'b1; col_fin = 1'b1;
            end
          end
        end else if (win_q && pos_q == 32'd33) begin
          if (acc_sh != bsd_pkg::COMP_RGB && acc_sh != bsd_pkg::COMP_BITFLD) begin
            list_o[n] = bsd_pkg::mk_res(bsd_pkg::KIND_ERR, 0, 0, 0, bsd_pkg::ERR_COMPRESS);
            n = n + 1'b1; phase_d = bsd_pkg::PH_IDLE;
          end else if (acc_sh == bsd_pkg::COMP_BITFLD && bpp_q <= 6'd8) begin
            list_o[n] = bsd_pkg::mk_res(bsd_pkg::KIND_ERR, 0, 0, 0, bsd_pkg::ERR_BF_DEPTH);
            n = n + 1'b1; phase_d = bsd_pkg::PH_IDLE;
          end else bf_d = (acc_sh == bsd_pkg::COMP_BITFLD);
        end else if (win_q && pos_q == 32'd49) begin
          col_en = 1'b1; col_val = acc_sh;
        end else if (win_q && pos_q == 32'd53) begin
          fin = 1'b1;
        end

        // colour count; zero means the full palette of the depth
        if (col_en) begin
          if (bpp_d > 6'd8) begin
            pcnt_d = '0; fin = col_fin;
          end else begin
            cnt = (col_val == 32'd0) ? (32'd1 << bpp_d) : col_val;
            if (cnt > 32'(MAX_COLOURS)) begin
              list_o[n] = bsd_pkg::mk_res(bsd_pkg::KIND_ERR, 0, 0, 0, bsd_pkg::ERR_COLOURS);
              n = n + 1'b1; phase_d = bsd_pkg::PH_IDLE;
            end else begin
              pcnt_d = cnt[8:0]; fin = col_fin;
            end
          end
        end

        // header result, then bitfield phase or the default masks
        if (fin) begin
          list_o[n] = bsd_pkg::mk_res(bsd_pkg::KIND_HEADER, 32'(wid_d), 32'(hgt_d),
                                      32'(bpp_d), bsd_pkg::ERR_NONE);
          n = n + 1'b1;
          if (bf_d) phase_d = bsd_pkg::PH_MASK;
          else begin
            if (bpp_d == 6'd16) begin
              list_o[n] = bsd_pkg::mk_res(bsd_pkg::KIND_MASK, 0, 0, bsd_pkg::M16_R,
                                          bsd_pkg::ERR_NONE);
              list_o[n+1] = bsd_pkg::mk_res(bsd_pkg::KIND_MASK, 1, 0, bsd_pkg::M16_G,
                                            bsd_pkg::ERR_NONE);
              list_o[n+2] = bsd_pkg::mk_res(bsd_pkg::KIND_MASK, 2, 0, bsd_pkg::M16_B,
                                            bsd_pkg::ERR_NONE);
              n = n + 3'd3;
            end else if (bpp_d == 6'd24 || bpp_d == 6'd32) begin
              list_o[n] = bsd_pkg::mk_res(bsd_pkg::KIND_MASK, 0, 0, bsd_pkg::M24_R,
                                          bsd_pkg::ERR_NONE);
              list_o[n+1] = bsd_pkg::mk_res(bsd_pkg::KIND_MASK, 1, 0, bsd_pkg::M24_G,
                                            bsd_pkg::ERR_NONE);
              list_o[n+2] = bsd_pkg::mk_res(bsd_pkg::KIND_MASK, 2, 0, bsd_pkg::M24_B,
                                            bsd_pkg::ERR_NONE);
              n = n + 3'd3;
            end
            am = 1'b1;
          end
        end
      end

      bsd_pkg::PH_MASK: begin
        if (mk[1:0] == 2'd3) begin
          list_o[n] = bsd_pkg::mk_res(bsd_pkg::KIND_MASK, 32'(mk[3:2]), 0, acc_sh,
                                      bsd_pkg::ERR_NONE);
          n = n + 1'b1;
        end
        if (mk == 4'd11) am = 1'b1;
      end

      bsd_pkg::PH_PAL: begin
        case (psub_q)
          2'd0: gath_d = {16'd0, file_byte_i};
          2'd1: gath_d[15:8] = file_byte_i;
          2'd2: begin
            gath_d[23:16] = file_byte_i;
            list_o[n] = bsd_pkg::mk_res(bsd_pkg::KIND_PAL, 32'(pent_q), 0,
                                        bsd_pkg::OPAQUE | {8'd0, gath_d}, bsd_pkg::ERR_NONE);
            n = n + 1'b1;
          end
          default: ;
        endcase
        if (psub_q == (win_q ? 2'd3 : 2'd2)) begin
          psub_d = '0;
          pent_d = pent_q + 9'd1;
          if (pent_q + 9'd1 == pcnt_q) go_data = 1'b1;
        end else psub_d = psub_q + 2'd1;
      end

      bsd_pkg::PH_SKIP: begin
        if (pos_q + 32'd1 >= off_q) go_pix = 1'b1;
      end

      bsd_pkg::PH_PIX: begin
        if (bpp_q == 6'd1) begin
          for (int k = 0; k < 8; k++) begin
            x = {rbc_q, 3'(k)};
            if (x < (PW+3)'(wid_q)) begin
              list_o[n] = bsd_pkg::mk_res(bsd_pkg::KIND_PIX, 32'(x), 32'(row_q),
                                          {31'd0, file_byte_i[7-k]}, bsd_pkg::ERR_NONE);
              n = n + 1'b1;
            end
          end
        end else if (bpp_q == 6'd4) begin
          x = {1'b0, rbc_q, 1'b0, 1'b0};
          x = x >> 1;
          if (x < (PW+3)'(wid_q)) begin
            list_o[n] = bsd_pkg::mk_res(bsd_pkg::KIND_PIX, 32'(x), 32'(row_q),
                                        {28'd0, file_byte_i[7:4]}, bsd_pkg::ERR_NONE);
            n = n + 1'b1;
          end
          if (x + (PW+3)'(1) < (PW+3)'(wid_q)) begin
            list_o[n] = bsd_pkg::mk_res(bsd_pkg::KIND_PIX, 32'(x) + 32'd1, 32'(row_q),
                                        {28'd0, file_byte_i[3:0]}, bsd_pkg::ERR_NONE);
            n = n + 1'b1;
          end
        end else if (bpp_q == 6'd8) begin
          if ((PW+3)'(rbc_q) < (PW+3)'(wid_q)) begin
            list_o[n] = bsd_pkg::mk_res(bsd_pkg::KIND_PIX, 32'(rbc_q), 32'(row_q),
                                        {24'd0, file_byte_i}, bsd_pkg::ERR_NONE);
            n = n + 1'b1;
          end
        end else begin
          if ((PW+3)'(rbc_q) < (PW+3)'(rawlim)) begin
            list_o[n] = bsd_pkg::mk_res(bsd_pkg::KIND_RAW, 32'(rbc_q), 32'(row_q),
                                        {24'd0, file_byte_i}, bsd_pkg::ERR_NONE);
            n = n + 1'b1;
          end
        end
        // row end: step up one row, or finish after the top row
        if (rbc_n >= pitch_q) begin
          if (row_q == '0) begin
            list_o[n] = bsd_pkg::mk_res(bsd_pkg::KIND_DONE, 0, 0, 0, bsd_pkg::ERR_NONE);
            n = n + 1'b1; phase_d = bsd_pkg::PH_IDLE;
            rbc_d = rbc_n;
          end else begin
            row_d = row_q - HW'(1); rbc_d = '0;
          end
        end else rbc_d = rbc_n;
      end

      default: ;
    endcase

    // end of header and masks: palette or on toward pixel data
    if (am) begin
      if (pcnt_d != '0) begin
        phase_d = bsd_pkg::PH_PAL; pent_d = '0; psub_d = '0;
      end else go_data = 1'b1;
    end

    if (go_data) begin
      if (off_q < pos_q + 32'd1) begin
        list_o[n] = bsd_pkg::mk_res(bsd_pkg::KIND_ERR, 0, 0, 0, bsd_pkg::ERR_OFFSET);
        n = n + 1'b1; phase_d = bsd_pkg::PH_IDLE;
      end else if (off_q == pos_q + 32'd1) go_pix = 1'b1;
      else phase_d = bsd_pkg::PH_SKIP;
    end

    // pixel data begins: row pitch rounded to four bytes
    prod = (WW+6)'(bpp_d) * (WW+6)'(wid_d);
    pbytes = (PW+2)'((prod + (WW+6)'(7)) >> 3) + (PW+2)'(3);
    if (go_pix) begin
      pitch_d = {pbytes[PW-1:2], 2'b00};
      rbc_d = '0;
      if (wid_d == '0 || hgt_d == '0) begin
        list_o[n] = bsd_pkg::mk_res(bsd_pkg::KIND_DONE, 0, 0, 0, bsd_pkg::ERR_NONE);
        n = n + 1'b1; phase_d = bsd_pkg::PH_IDLE;
      end else begin
        row_d = hgt_d - HW'(1); phase_d = bsd_pkg::PH_PIX;
      end
    end

    // end of file: flag a cut-short image and return to reset state
    if (end_of_file_i) begin
      if (phase_d != bsd_pkg::PH_IDLE) begin
        list_o[n] = bsd_pkg::mk_res(bsd_pkg::KIND_ERR, 0, 0, 0, bsd_pkg::ERR_EARLY);
        n = n + 1'b1;
      end
      phase_d = bsd_pkg::PH_HEAD;
      pos_d = '0; acc_d = '0; off_d = '0; win_d = 1'b0; bf_d = 1'b0;
      wid_d = '0; hgt_d = '0; row_d = '0; bpp_d = '0;
      pcnt_d = '0; pent_d = '0; psub_d = '0; rbc_d = '0; pitch_d = '0; gath_d = '0;
    end

    if (n != '0) list_o[n - 1'b1].last = 1'b1;
    count_o = n;
  end

endmodule
`default_nettype wire

>>> rtl/bsd_result_buf.sv
// bsd_result_buf: holds the result list of one byte and hands it out one beat
// per cycle while out_stall_i is low. Depends on bsd_pkg.
`default_nettype none
module bsd_result_buf (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  load_i,
  input  wire bsd_pkg::res_t         list_i [bsd_pkg::RES_MAX],
  input  wire logic [bsd_pkg::RES_CW-1:0] count_i,
  output logic                       can_load_o,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output bsd_pkg::res_t              res_o
);

  bsd_pkg::res_t              ent_q [bsd_pkg::RES_MAX];
  logic [bsd_pkg::RES_CW-1:0] cnt_q, rd_q;
  logic                       take;

  assign out_valid_o = (rd_q < cnt_q);
  assign take        = out_valid_o && !out_stall_i;
  assign can_load_o  = !out_valid_o || (take && (rd_q + 1'b1 == cnt_q));
  assign res_o       = ent_q[rd_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (load_i) ent_q <= list_i;
  end

  // read pointer and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
    end else if (load_i) begin
      cnt_q <= count_i;
      rd_q  <= '0;
    end else if (take) begin
      rd_q <= rd_q + 1'b1;
    end
  end

endmodule
`default_nettype wire

>>> rtl/bmp_stream_decoder_unit.sv
// Streaming bitmap decoder: one file byte per beat in, typed results out.
// Latency: a byte's first result is valid the cycle after the byte is taken.
// Throughput: one byte per cycle while each byte gives at most one result and no
// output stall; a byte with more results holds the input until its last is taken.
// Reset: asynchronous, active low; parser waits for the magic, buffer empty.
`default_nettype none
module bmp_stream_decoder_unit #(
  parameter int unsigned MAX_WIDTH   = 4096,
  parameter int unsigned MAX_HEIGHT  = 4096,
  parameter int unsigned MAX_COLOURS = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  file_byte_i,
  input  wire logic        end_of_file_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       item_kind_o,
  output logic [13:0]      column_o,
  output logic [11:0]      row_o,
  output logic [31:0]      payload_o,
  output logic [3:0]       error_code_o,
  output logic             last_of_run_o
);

  bsd_pkg::res_t              list [bsd_pkg::RES_MAX];
  bsd_pkg::res_t              res;
  logic [bsd_pkg::RES_CW-1:0] count;
  logic                       can_load, accept;

  assign in_stall_o = !can_load;
  assign accept     = in_valid_i && can_load;

  bsd_parser #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_COLOURS(MAX_COLOURS)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .file_byte_i  (file_byte_i),
    .end_of_file_i(end_of_file_i),
    .list_o       (list),
    .count_o      (count)
  );

  bsd_result_buf u_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept),
    .list_i     (list),
    .count_i    (count),
    .can_load_o (can_load),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .res_o      (res)
  );

  assign item_kind_o   = res.kind;
  assign column_o      = res.column;
  assign row_o         = res.row;
  assign payload_o     = res.payload;
  assign error_code_o  = res.err;
  assign last_of_run_o = res.last;

`ifndef ASSERT_OFF
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && item_kind_o != bsd_pkg::KIND_ERR |-> error_code_o == bsd_pkg::ERR_NONE)
    else $error("error code outside an error beat");
  a_err_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && item_kind_o == bsd_pkg::KIND_ERR |-> error_code_o != bsd_pkg::ERR_NONE)
    else $error("error beat without a code");
  a_stall_why: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");
  a_run_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |-> in_stall_o)
    else $error("byte taken in the middle of a result run");
`endif

endmodule
`default_nettype wire

>>> verif/bmp_stream_decoder_unit_tb.sv
// Testbench for bmp_stream_decoder_unit: builds bitmap files byte by byte,
// predicts every result in a scoreboard class and checks the output stream.
// Depends on rtl/bsd_pkg.sv and rtl/bmp_stream_decoder_unit.sv.
`default_nettype none
module bmp_stream_decoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bsd_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 3_000_000;
  localparam int unsigned MAXW = 4096;
  localparam int unsigned MAXH = 4096;
  localparam int unsigned MAXC = 256;

  // Decoder predictor plus the queue of results still owed by the block
  class bmp_scoreboard;
    phase_e      ph;
    int unsigned fpos, acc, data_off, win, width, height, bpp, bitf;
    int unsigned pal_cnt, pal_prog, cur_row, row_bytes, gather, pitch;
    res_t        pending_q[$];
    res_t        burst_q[$];
    int unsigned errs;

    function new();
      errs = 0;
      clear();
    endfunction

    function void clear();
      ph = PH_HEAD; fpos = 0; acc = 0; data_off = 0; win = 0; width = 0;
      height = 0; bpp = 0; bitf = 0; pal_cnt = 0; pal_prog = 0; cur_row = 0;
      row_bytes = 0; gather = 0; pitch = 0;
    endfunction

    function void put(kind_e k, int unsigned c, int unsigned r, int unsigned p, err_e e);
      res_t x;
      if (burst_q.size() >= RES_MAX) return;
      x.kind = k; x.column = c[13:0]; x.row = r[11:0]; x.payload = p;
      x.err = e; x.last = 1'b0;
      burst_q.push_back(x);
    endfunction

    function void fail_with(err_e e);
      put(KIND_ERR, 0, 0, 0, e);
      ph = PH_IDLE;
    endfunction

    function void start_rows();
      pitch = (((bpp * width + 7) >> 3) + 3) & ~32'd3;
      row_bytes = 0;
      if (width == 0 || height == 0) begin
        put(KIND_DONE, 0, 0, 0, ERR_NONE);
        ph = PH_IDLE;
        return;
      end
      cur_row = height - 1;
      ph = PH_PIX;
    endfunction

    function void to_data(int unsigned pos);
      if (data_off < pos + 1) fail_with(ERR_OFFSET);
      else if (data_off == pos + 1) start_rows();
      else ph = PH_SKIP;
    endfunction

    function void after_masks(int unsigned pos);
      if (pal_cnt > 0) begin
        pal_prog = 0;
        ph = PH_PAL;
      end else to_data(pos);
    endfunction

    function bit set_palette(int unsigned v);
      int unsigned cnt;
      if (bpp > 8) begin
        pal_cnt = 0;
        return 1;
      end
      cnt = (v == 0) ? (32'd1 << bpp) : v;
      if (cnt > MAXC) begin
        fail_with(ERR_COLOURS);
        return 0;
      end
      pal_cnt = cnt;
      return 1;
    endfunction

    function void close_header(int unsigned pos);
      put(KIND_HEADER, width, height, bpp, ERR_NONE);
      if (bitf != 0) begin
        ph = PH_MASK;
        return;
      end
      if (bpp == 16) begin
        put(KIND_MASK, 0, 0, M16_R, ERR_NONE);
        put(KIND_MASK, 1, 0, M16_G, ERR_NONE);
        put(KIND_MASK, 2, 0, M16_B, ERR_NONE);
      end else if (bpp == 24 || bpp == 32) begin
        put(KIND_MASK, 0, 0, M24_R, ERR_NONE);
        put(KIND_MASK, 1, 0, M24_G, ERR_NONE);
        put(KIND_MASK, 2, 0, M24_B, ERR_NONE);
      end
      after_masks(pos);
    endfunction

    function void header_byte(int unsigned b, int unsigned pos);
      int unsigned v;
      if (pos == 0) begin
        if (b != MAGIC_B) fail_with(ERR_NOT_BMP);
        return;
      end
      if (pos == 1) begin
        if (b != MAGIC_M) fail_with(ERR_NOT_BMP);
        return;
      end
      if (pos == 13) begin
        data_off = acc;
        return;
      end
      if (pos == 17) begin
        if (acc == HDR_OS2) win = 0;
        else if (acc == HDR_WIN) win = 1;
        else fail_with(ERR_HDR_SIZE);
        return;
      end
      if (pos == (win ? 21 : 19)) begin
        v = win ? acc : (acc >> 16);
        if (v > MAXW) fail_with(ERR_TOO_BIG); else width = v;
      end else if (pos == (win ? 25 : 21)) begin
        v = win ? acc : (acc >> 16);
        if (v > MAXH) fail_with(ERR_TOO_BIG); else height = v;
      end else if (pos == (win ? 27 : 23)) begin
        if ((acc >> 16) != 1) fail_with(ERR_PLANES);
      end else if (pos == (win ? 29 : 25)) begin
        v = acc >> 16;
        if (!(v == 1 || v == 4 || v == 8 || v == 16 || v == 24 || v == 32)) begin
          fail_with(ERR_DEPTH);
          return;
        end
        bpp = v;
        if (win == 0 && set_palette(0)) close_header(pos);
      end else if (win != 0 && pos == 33) begin
        if (acc != COMP_RGB && acc != COMP_BITFLD) fail_with(ERR_COMPRESS);
        else if (acc == COMP_BITFLD && bpp <= 8) fail_with(ERR_BF_DEPTH);
        else bitf = (acc == COMP_BITFLD);
      end else if (win != 0 && pos == 49) begin
        void'(set_palette(acc));
      end else if (win != 0 && pos == 53) begin
        close_header(pos);
      end
    endfunction

    function void pixel_byte(int unsigned b);
      int unsigned x;
      if (bpp == 1) begin
        for (int k = 0; k < 8; k++) begin
          x = row_bytes * 8 + k;
          if (x < width) put(KIND_PIX, x, cur_row, (b >> (7 - k)) & 1, ERR_NONE);
        end
      end else if (bpp == 4) begin
        x = row_bytes * 2;
        if (x < width) put(KIND_PIX, x, cur_row, (b >> 4) & 'h0F, ERR_NONE);
        if (x + 1 < width) put(KIND_PIX, x + 1, cur_row, b & 'h0F, ERR_NONE);
      end else if (bpp == 8) begin
        if (row_bytes < width) put(KIND_PIX, row_bytes, cur_row, b, ERR_NONE);
      end else begin
        if (row_bytes < width * (bpp >> 3)) put(KIND_RAW, row_bytes, cur_row, b, ERR_NONE);
      end
      row_bytes++;
      if (row_bytes >= pitch) begin
        if (cur_row == 0) begin
          put(KIND_DONE, 0, 0, 0, ERR_NONE);
          ph = PH_IDLE;
        end else begin
          cur_row--;
          row_bytes = 0;
        end
      end
    endfunction

    // One accepted file byte: advance the parser and queue its results
    function void note_byte(logic [7:0] fb, logic eof);
      int unsigned b, pos, es, e, s, k;
      b = fb;
      pos = fpos;
      burst_q.delete();
      if (ph == PH_HEAD || ph == PH_MASK) acc = (acc >> 8) | (b << 24);
      case (ph)
        PH_HEAD: header_byte(b, pos);
        PH_MASK: begin
          k = pos - 54;
          if ((k & 3) == 3) put(KIND_MASK, k >> 2, 0, acc, ERR_NONE);
          if (k >= 11) after_masks(pos);
        end
        PH_PAL: begin
          es = win ? 4 : 3;
          e = pal_prog / es;
          s = pal_prog - e * es;
          if (s == 0) gather = b;
          else if (s == 1) gather |= b << 8;
          else if (s == 2) begin
            gather |= b << 16;
            put(KIND_PAL, e, 0, OPAQUE | gather, ERR_NONE);
          end
          pal_prog++;
          if (pal_prog >= pal_cnt * es) to_data(pos);
        end
        PH_SKIP: if (pos + 1 >= data_off) start_rows();
        PH_PIX: pixel_byte(b);
        default: ;
      endcase
      fpos = pos + 1;
      if (eof) begin
        if (ph != PH_IDLE) put(KIND_ERR, 0, 0, 0, ERR_EARLY);
        clear();
      end
      if (burst_q.size() > 0) burst_q[burst_q.size() - 1].last = 1'b1;
      foreach (burst_q[i]) pending_q.push_back(burst_q[i]);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending_q.size() == 0) begin
        $error("unexpected result kind=%0d col=%0d row=%0d payload=%h",
               got.kind, got.column, got.row, got.payload);
        errs++;
        return;
      end
      want = pending_q.pop_front();
      if (got.kind != want.kind) begin
        $error("item_kind: expected %0d, got %0d", want.kind, got.kind); errs++;
      end
      if (got.column != want.column) begin
        $error("column: expected %0d, got %0d", want.column, got.column); errs++;
      end
      if (got.row != want.row) begin
        $error("row: expected %0d, got %0d", want.row, got.row); errs++;
      end
      if (got.payload != want.payload) begin
        $error("payload: expected %h, got %h", want.payload, got.payload); errs++;
      end
      if (got.err != want.err) begin
        $error("error_code: expected %0d, got %0d", want.err, got.err); errs++;
      end
      if (got.last != want.last) begin
        $error("last_of_run: expected %0b, got %0b", want.last, got.last); errs++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  file_byte_i;
  logic        end_of_file_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  item_kind_o;
  logic [13:0] column_o;
  logic [11:0] row_o;
  logic [31:0] payload_o;
  logic [3:0]  error_code_o;
  logic        last_of_run_o;

  bmp_stream_decoder_unit u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .file_byte_i, .end_of_file_i,
    .out_valid_o, .out_stall_i, .item_kind_o, .column_o, .row_o, .payload_o,
    .error_code_o, .last_of_run_o
  );

  bmp_scoreboard sb = new();
  logic [7:0]    file_q[$];
  bit            hold_req = 0;
  bit            quiet_mode = 0;
  int unsigned   cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("bmp_stream_decoder_unit_tb: errors");
      $finish;
    end
  end

  // Monitor: input beats feed the predictor, output beats get checked
  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_byte(file_byte_i, end_of_file_i);
      if (out_valid_o && !out_stall_i) begin
        got.kind = kind_e'(item_kind_o); got.column = column_o; got.row = row_o;
        got.payload = payload_o; got.err = err_e'(error_code_o);
        got.last = last_of_run_o;
        sb.check_result(got);
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Result side back-pressure, with one long hold-off on request
  initial begin
    int unsigned n;
    out_stall_i = 1'b0;
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
        hold_req = 0;
      end
      n = pick_gap();
      out_stall_i <= (n != 0);
      repeat ((n == 0) ? $urandom_range(1, 8) : n) @(posedge clk_i);
    end
  end

  task automatic put_le(int unsigned v, int nbytes);
    for (int i = 0; i < nbytes; i++) file_q.push_back(8'(v >> (8 * i)));
  endtask

  // Assemble one file into file_q; extra shifts the data offset,
  // cut > 0 truncates the file, trail appends junk after the image
  task automatic build_file(bit wf, int unsigned w, int unsigned h, int unsigned bits,
                            int unsigned comp, int unsigned clr, int unsigned hsize,
                            int unsigned planes, int extra, int unsigned cut,
                            int unsigned trail);
    int unsigned ncol, es, off, pitch_b, dlen;
    bit bf;
    file_q.delete();
    bf = wf && comp == COMP_BITFLD;
    es = wf ? 4 : 3;
    ncol = (bits <= 8) ? ((wf && clr != 0) ? clr : (32'd1 << bits)) : 0;
    if (ncol > MAXC) ncol = 0;
    off = 14 + (wf ? 40 : 12) + (bf ? 12 : 0) + ncol * es;
    off = int'(off) + extra;
    file_q.push_back(MAGIC_B);
    file_q.push_back(MAGIC_M);
    put_le($urandom, 4);
    put_le($urandom, 4);
    put_le(off, 4);
    put_le(hsize, 4);
    if (wf) begin
      put_le(w, 4); put_le(h, 4); put_le(planes, 2); put_le(bits, 2);
      put_le(comp, 4); put_le($urandom, 4); put_le($urandom, 4); put_le($urandom, 4);
      put_le(clr, 4); put_le($urandom, 4);
    end else begin
      put_le(w, 2); put_le(h, 2); put_le(planes, 2); put_le(bits, 2);
    end
    if (bf) for (int i = 0; i < 3; i++) put_le($urandom, 4);
    for (int i = 0; i < ncol * es; i++) file_q.push_back(8'($urandom));
    while (file_q.size() < off) file_q.push_back(8'($urandom));
    pitch_b = (((bits * w + 7) >> 3) + 3) & ~32'd3;
    dlen = (w <= MAXW && h <= MAXH) ? pitch_b * h : 8;
    if (dlen > 20000) dlen = 8;
    for (int i = 0; i < dlen + trail; i++) file_q.push_back(8'($urandom));
    if (cut > 0 && cut < file_q.size()) file_q = file_q[0:cut - 1];
  endtask

  task automatic send_byte(logic [7:0] b, logic eof);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    file_byte_i   <= b;
    end_of_file_i <= eof;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_file();
    foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
  endtask

  // Wait for the next edge first so the last accepted beat is in the predictor
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    in_valid_i    = 1'b0;
    file_byte_i   = 8'h00;
    end_of_file_i = 1'b0;
    rst_ni        = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Short files, mostly cut right after the byte that carries the fault
    build_file(0, 2, 1, 24, COMP_RGB, 0, HDR_OS2, 1, 0, 2, 0);
    file_q[0] = 8'h58;
    send_file();
    build_file(0, 2, 1, 24, COMP_RGB, 0, 20, 1, 0, 18, 0);
    send_file();
    build_file(0, 2, 1, 3, COMP_RGB, 0, HDR_OS2, 1, 0, 26, 0);
    send_file();
    build_file(0, MAXW + 1, 1, 24, COMP_RGB, 0, HDR_OS2, 1, 0, 20, 0);
    send_file();
    build_file(0, 1, 1, 24, COMP_RGB, 0, HDR_OS2, 1, -1, 26, 0);
    send_file();

    // Complete raw image with a skip and junk after done, back to back
    build_file(0, 1, 1, 24, COMP_RGB, 0, HDR_OS2, 1, 1, 0, 2);
    quiet_mode = 1;
    send_file();
    quiet_mode = 0;

    // 1-bit rows while the result side holds off: fills the block
    drain();
    build_file(0, 16, 1, 1, COMP_RGB, 0, HDR_OS2, 1, 0, 0, 0);
    hold_req = 1;
    send_file();

    // Sender waits for every owed result, then a file cut in its pixels
    drain();
    build_file(0, 3, 2, 16, COMP_RGB, 0, HDR_OS2, 1, 0, 28, 0);
    send_file();

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.errs == 0 && sb.pending_q.size() == 0) begin
      $display("bmp_stream_decoder_unit_tb: clean");
    end else begin
      $display("bmp_stream_decoder_unit_tb: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> bmp_stream_decoder_unit.f
rtl/bsd_pkg.sv
rtl/bsd_parser.sv
rtl/bsd_result_buf.sv
rtl/bmp_stream_decoder_unit.sv
verif/bmp_stream_decoder_unit_tb.sv
